>>> hdl/dnae_pkg.sv
// Package for the DAG node evaluator: command codes, store depth default,
// and the shared queue entry type. No dependencies.
package dnae_pkg;
	localparam int DEPTH_DEF = 4096;
	localparam int AW_IN = 12;
	localparam logic [1:0] CMD_WRITE = 2'd0;
	localparam logic [1:0] CMD_EVAL  = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;
	localparam logic       OP_ADD    = 1'b0;
	localparam logic       OP_MUL    = 1'b1;

	typedef struct packed {
		logic [1:0]        cmd;
		logic              op;
		logic [AW_IN-1:0]  a;
		logic [AW_IN-1:0]  b;
		logic [AW_IN-1:0]  d;
		logic [31:0]       wv;
	} cmd_t;
endpackage

>>> hdl/dag_node_add_mul_evaluator_top.sv
// Top level of the DAG node evaluator; ties the command queue to the back end.
// Depends on dnae_pkg, dnae_front and dnae_back.
//
// Usage: commands enter as queue beats (push/full) with command, op_select,
// operand addresses, dest_addr and write_value. Each command gives one result
// beat (empty/pop) with result_value and result_addr.
// write stores write_value; evaluate adds or multiplies two stored binary32
// values (RNE, subnormals flushed) and stores the result; read returns a value.
// The back end reads the store as it takes a command, then computes and writes
// back in its execute state, taking no new command until that one is written,
// so a node sees the value the previous one wrote.
// A two-entry command queue keeps accepting while the result waits; when the
// receiver stalls the back end holds its command and the queue fills, then
// full rises. Reset empties the queue and the result register; store contents
// are undefined until written.
module dag_node_add_mul_evaluator_top import dnae_pkg::*; #(
	parameter int STORE_DEPTH = DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic [1:0]        command,
	input  logic              op_select,
	input  logic [AW_IN-1:0]  src_a_addr,
	input  logic [AW_IN-1:0]  src_b_addr,
	input  logic [AW_IN-1:0]  dest_addr,
	input  logic [31:0]       write_value,
	output logic              empty,
	input  logic              pop,
	output logic [31:0]       result_value,
	output logic [AW_IN-1:0]  result_addr
);
	cmd_t in_cmd, q_cmd;
	logic cv, ct;

	assign in_cmd = '{cmd: command, op: op_select, a: src_a_addr, b: src_b_addr,
		d: dest_addr, wv: write_value};

	dnae_front u_front (.clk, .arst_n, .push, .full, .in_cmd,
		.cv, .ct, .c_out(q_cmd));

	dnae_back #(.STORE_DEPTH(STORE_DEPTH)) u_back (.clk, .arst_n, .cv, .ct,
		.c_in(q_cmd), .empty, .pop, .result_value, .result_addr);

	// back end only takes a command the queue holds
	a_take: assert property (@(posedge clk) disable iff (!arst_n) ct |-> cv)
		else $error("command taken from empty queue");
	// a held result stays put while not popped
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result_value) && $stable(result_addr)))
		else $error("result changed while stalled");
	// a full queue stays full until the back end takes a command
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		(full && !ct) |=> full)
		else $error("queue lost an entry");
endmodule

>>> hdl/dnae_front.sv
// Front end: two-entry command queue between the input port and the back end.
// Depends on dnae_pkg.
module dnae_front import dnae_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  cmd_t in_cmd,
	output logic cv,
	input  logic ct,
	output cmd_t c_out
);
	cmd_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic do_w, do_r;

	assign full  = cnt_q[1];
	assign cv    = cnt_q != 2'd0;
	assign do_w  = push && !full;
	assign do_r  = ct && cv;
	assign c_out = mem_q[rp_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_w) mem_q[wp_q] <= in_cmd;
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
		end else begin
			if (do_w) wp_q <= !wp_q;
			if (do_r) rp_q <= !rp_q;
			cnt_q <= cnt_q + {1'b0, do_w} - {1'b0, do_r};
		end
	end
endmodule

>>> hdl/dnae_fpu.sv
// Combinational binary32 add/multiply with RNE and flush to zero.
// Depends on dnae_pkg.
module dnae_fpu import dnae_pkg::*; (
	input  logic        op,
	input  logic [31:0] x,
	input  logic [31:0] y,
	output logic [31:0] r
);
	localparam logic [31:0] QNAN = 32'h7FC00000;

	function automatic logic [31:0] rpack(input logic s, input logic signed [10:0] e,
			input logic [49:0] m);
		logic [5:0]  p;
		logic [49:0] nm;
		logic [23:0] q;
		logic [25:0] lost;
		logic        rup;
		logic [24:0] q1;
		logic signed [11:0] be;
		p = 6'd0;
		for (int i = 0; i < 50; i++) if (m[i]) p = 6'(i);
		nm = m << (6'd49 - p);
		q = nm[49:26];
		lost = nm[25:0];
		rup = lost[25] && ((lost[24:0] != 25'd0) || q[0]);
		q1 = {1'b0, q} + {24'd0, rup};
		be = 12'(e) + 12'(p) + 12'sd127;
		if (q1[24]) begin
			be = be + 12'sd1; q1 = q1 >> 1;
		end
		if (be >= 12'sd255) rpack = {s, 8'hFF, 23'd0};
		else if (be < 12'sd1) rpack = {s, 31'd0};
		else rpack = {s, be[7:0], q1[22:0]};
	endfunction

	logic xn, yn, xi, yi, xz, yz, sx, sy;
	logic [7:0] ex, ey, eb, es;
	logic [23:0] mx, my, mbg, msm;
	logic sbg, ssm, sres;
	logic [7:0] dd;
	logic [49:0] big, sh, sum;
	logic [47:0] prod;
	logic sticky;

	always_comb begin
		sx = x[31]; sy = y[31];
		ex = x[30:23]; ey = y[30:23];
		xn = (ex == 8'hFF) && (x[22:0] != 0); yn = (ey == 8'hFF) && (y[22:0] != 0);
		xi = (ex == 8'hFF) && (x[22:0] == 0); yi = (ey == 8'hFF) && (y[22:0] == 0);
		xz = ex == 8'd0; yz = ey == 8'd0;
		mx = {1'b1, x[22:0]}; my = {1'b1, y[22:0]};
		if (ex >= ey) begin
			eb = ex; es = ey; mbg = mx; msm = my; sbg = sx; ssm = sy;
		end else begin
			eb = ey; es = ex; mbg = my; msm = mx; sbg = sy; ssm = sx;
		end
		dd = eb - es;
		// 24b mantissa below a carry bit with 25 guard bits; sticky collapses the rest
		big = {1'b0, mbg, 25'd0};
		sticky = 1'b0;
		if (dd >= 8'd50) begin
			sh = 50'd1;
		end else begin
			sh = {1'b0, msm, 25'd0} >> dd;
			sticky = (({1'b0, msm, 25'd0} & ~({50{1'b1}} << dd)) != 50'd0);
			sh[0] = sh[0] | sticky;
		end
		prod = mx * my;
		sum = 50'd0;
		sres = sbg;
		r = 32'd0;
		if (op == OP_MUL) begin
			if (xn || yn) r = QNAN;
			else if (xi || yi) r = (xz || yz) ? QNAN : {sx ^ sy, 8'hFF, 23'd0};
			else if (xz || yz) r = {sx ^ sy, 31'd0};
			else r = rpack(sx ^ sy, 11'(ex) + 11'(ey) - 11'sd300, {2'b0, prod});
		end else begin
			if (xn || yn) r = QNAN;
			else if (xi && yi) r = (sx == sy) ? x : QNAN;
			else if (xi) r = x;
			else if (yi) r = y;
			else if (xz && yz) r = {sx & sy, 31'd0};
			else if (xz) r = y;
			else if (yz) r = x;
			else begin
				// equal exponents can leave the smaller operand on top
				if (sbg == ssm) sum = big + sh;
				else if (big >= sh) sum = big - sh;
				else begin
					sum = sh - big; sres = ssm;
				end
				if (sum == 50'd0) r = 32'd0;
				else r = rpack(sres, 11'(eb) - 11'sd175, sum);
			end
		end
	end
endmodule

>>> hdl/dnae_back.sv
// Back end: value store, operand fetch, FPU and write-back.
// Depends on dnae_pkg and dnae_fpu.
module dnae_back import dnae_pkg::*; #(
	parameter int STORE_DEPTH = DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cv,
	output logic        ct,
	input  cmd_t        c_in,
	output logic        empty,
	input  logic        pop,
	output logic [31:0] result_value,
	output logic [AW_IN-1:0] result_addr
);
	localparam int AW = $clog2(STORE_DEPTH);
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;

	logic [31:0] store_q [STORE_DEPTH];
	logic [1:0] st_q;
	cmd_t cur_q;
	logic [31:0] ra_q, rb_q, res;
	logic [AW-1:0] ia, ib, id, cd;
	logic out_v_q, take, wr_en, fire;
	logic [31:0] fres, wdat;

	// out register frees when empty or popped this cycle
	assign empty = !out_v_q;
	assign fire  = (st_q == ST_EXEC) && !(out_v_q && !pop);
	assign ct    = (st_q == ST_IDLE) && cv;
	assign take  = ct;
	assign ia    = AW'(c_in.a % STORE_DEPTH);
	assign ib    = AW'(c_in.b % STORE_DEPTH);
	assign id    = AW'(c_in.d % STORE_DEPTH);
	assign cd    = AW'(cur_q.d % STORE_DEPTH);

	dnae_fpu u_fpu (.op(cur_q.op), .x(ra_q), .y(rb_q), .r(fres));

	// result selection for the executing command
	always_comb begin
		case (cur_q.cmd)
			CMD_WRITE: res = cur_q.wv;
			CMD_EVAL:  res = fres;
			default:   res = ra_q;
		endcase
	end
	assign wr_en = fire && (cur_q.cmd == CMD_WRITE || cur_q.cmd == CMD_EVAL);
	assign wdat = res;

	// store: read on accept, write at end of execute
	always_ff @(posedge clk) begin
		if (take) begin
			ra_q <= store_q[(c_in.cmd == CMD_EVAL) ? ia : id];
			rb_q <= store_q[ib];
			cur_q <= c_in;
		end
		if (wr_en) store_q[cd] <= wdat;
		if (fire) begin
			result_value <= res;
			result_addr  <= cur_q.d;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE; out_v_q <= 1'b0;
		end else begin
			out_v_q <= fire || (out_v_q && !pop);
			case (st_q)
				ST_IDLE: if (take) st_q <= ST_EXEC;
				ST_EXEC: if (fire) st_q <= ST_IDLE;
				default: st_q <= ST_IDLE;
			endcase
		end
	end
endmodule

>>> tb/sv/dag_node_add_mul_evaluator_top_tb.sv
// Self-checking bench for dag_node_add_mul_evaluator_top: write, evaluate and read beats
// are checked against an in-bench binary32 store model. Depends on dnae_pkg and the RTL top.
`timescale 1ns / 100ps

module dag_node_add_mul_evaluator_top_tb;
	import dnae_pkg::*;

	localparam int NODES = 4096;
	// spare command code, behaves as read
	localparam logic [1:0] CMD_SPARE = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic pop = 1'b0;
	logic [1:0] command = CMD_WRITE;
	logic op_select = OP_ADD;
	logic [AW_IN-1:0] src_a_addr = '0;
	logic [AW_IN-1:0] src_b_addr = '0;
	logic [AW_IN-1:0] dest_addr = '0;
	logic [31:0] write_value = '0;
	logic full, empty;
	logic [31:0] result_value;
	logic [AW_IN-1:0] result_addr;

	typedef struct {
		logic [31:0] value;
		logic [AW_IN-1:0] addr;
	} node_result_t;

	cmd_t pending_cmds[$];
	node_result_t expected_results[$];
	logic [31:0] node_values [NODES];
	bit node_written [NODES];
	int written_addrs[$];
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int errors = 0;
	cmd_t next_cmd;

	dag_node_add_mul_evaluator_top uut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.command(command), .op_select(op_select), .src_a_addr(src_a_addr),
		.src_b_addr(src_b_addr), .dest_addr(dest_addr), .write_value(write_value),
		.empty(empty), .pop(pop), .result_value(result_value), .result_addr(result_addr)
	);

	always #1 clk = ~clk;

	// binary32 helpers, subnormals flushed
	function automatic bit f_nan(logic [31:0] x);
		return x[30:23] == 8'hFF && x[22:0] != 0;
	endfunction
	function automatic bit f_inf(logic [31:0] x);
		return x[30:23] == 8'hFF && x[22:0] == 0;
	endfunction
	function automatic bit f_zero(logic [31:0] x);
		return x[30:23] == 8'h00;
	endfunction

	// round m * 2^e to nearest even, overflow to inf, tiny to signed zero
	function automatic logic [31:0] fp_round(logic s, int e, logic [63:0] m);
		int p, sh, ex, be;
		logic [63:0] q, lost, half;
		p = 63;
		while (!m[p]) p--;
		if (p > 23) begin
			sh = p - 23;
			lost = m & ((64'd1 << sh) - 64'd1);
			half = 64'd1 << (sh - 1);
			q = m >> sh;
			if (lost > half || (lost == half && q[0])) q++;
			ex = e + sh;
			if (q >> 24) begin
				q = q >> 1;
				ex++;
			end
		end else begin
			q = m << (23 - p);
			ex = e - (23 - p);
		end
		be = ex + 150;
		if (be >= 255) return {s, 31'h7F800000};
		if (be < 1) return {s, 31'd0};
		return {s, be[7:0], q[22:0]};
	endfunction

	function automatic logic [31:0] fp_sum(logic [31:0] a, logic [31:0] b);
		logic sa, sb, st, ts;
		int ea, eb, d, te;
		logic [63:0] ma, mb, big, sm, r, tm;
		sa = a[31];
		sb = b[31];
		if (f_nan(a) || f_nan(b)) return 32'h7FC00000;
		if (f_inf(a) && f_inf(b)) return (sa == sb) ? a : 32'h7FC00000;
		if (f_inf(a)) return a;
		if (f_inf(b)) return b;
		if (f_zero(a) && f_zero(b)) return {sa & sb, 31'd0};
		if (f_zero(a)) return b;
		if (f_zero(b)) return a;
		ea = a[30:23];
		eb = b[30:23];
		ma = {41'd1, a[22:0]};
		mb = {41'd1, b[22:0]};
		if (ea < eb) begin
			te = ea; tm = ma; ts = sa;
			ea = eb; ma = mb; sa = sb;
			eb = te; mb = tm; sb = ts;
		end
		d = ea - eb;
		big = ma << 32;
		if (d >= 63) sm = 64'd1;
		else begin
			sm = (mb << 32) >> d;
			if ((sm << d) != (mb << 32)) sm[0] = 1'b1;
		end
		if (sa == sb) begin
			r = big + sm; st = sa;
		end else if (big >= sm) begin
			r = big - sm; st = sa;
		end else begin
			r = sm - big; st = sb;
		end
		if (r == 0) return 32'd0;
		return fp_round(st, ea - 182, r);
	endfunction

	function automatic logic [31:0] fp_product(logic [31:0] a, logic [31:0] b);
		logic s;
		int ea, eb;
		logic [63:0] ma, mb;
		s = a[31] ^ b[31];
		if (f_nan(a) || f_nan(b)) return 32'h7FC00000;
		if (f_inf(a) || f_inf(b)) begin
			if (f_zero(a) || f_zero(b)) return 32'h7FC00000;
			return {s, 31'h7F800000};
		end
		if (f_zero(a) || f_zero(b)) return {s, 31'd0};
		ea = a[30:23];
		eb = b[30:23];
		ma = {41'd1, a[22:0]};
		mb = {41'd1, b[22:0]};
		return fp_round(s, ea + eb - 300, ma * mb);
	endfunction

	// apply one accepted command to the bench's store, queue its result
	function automatic void evaluate_node(cmd_t c);
		logic [31:0] v;
		case (c.cmd)
			CMD_WRITE: begin
				v = c.wv;
				node_values[c.d] = v;
			end
			CMD_EVAL: begin
				v = (c.op == OP_MUL) ? fp_product(node_values[c.a], node_values[c.b])
					: fp_sum(node_values[c.a], node_values[c.b]);
				node_values[c.d] = v;
			end
			default: v = node_values[c.d];
		endcase
		expected_results.push_back('{v, c.d});
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("%0t: %s got %08h want %08h", $realtime, what, got, want);
		errors++;
	endtask

	// queue a command; addresses it writes count as written from then on
	function automatic void queue_cmd(logic [1:0] c, logic o, int a, int b, int d,
			logic [31:0] wv);
		pending_cmds.push_back('{c, o, a[AW_IN-1:0], b[AW_IN-1:0], d[AW_IN-1:0], wv});
		if ((c == CMD_WRITE || c == CMD_EVAL) && !node_written[d]) begin
			node_written[d] = 1'b1;
			written_addrs.push_back(d);
		end
	endfunction

	function automatic logic [31:0] rand_float();
		logic [31:0] r;
		r = $urandom;
		case ($urandom_range(0, 9))
			0: ;
			1: r[30:23] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
			2: r[30:23] = $urandom_range(0, 1) ? 8'($urandom_range(1, 4))
				: 8'($urandom_range(250, 254));
			default: r[30:23] = 8'($urandom_range(118, 136));
		endcase
		return r;
	endfunction

	// an address already written, biased to recent ones to build chains
	function automatic int pick_written();
		int n;
		n = written_addrs.size();
		if ($urandom_range(0, 1))
			return written_addrs[n - 1 - $urandom_range(0, (n < 8) ? n - 1 : 7)];
		return written_addrs[$urandom_range(0, n - 1)];
	endfunction

	function automatic void queue_random();
		int k;
		logic [1:0] c;
		k = $urandom_range(0, 99);
		if (written_addrs.size() < 4 || k < 15)
			queue_cmd(CMD_WRITE, 1'($urandom_range(0, 1)), $urandom, $urandom,
				$urandom_range(0, NODES - 1), rand_float());
		else if (k < 85)
			queue_cmd(CMD_EVAL, 1'($urandom_range(0, 1)), pick_written(), pick_written(),
				$urandom_range(0, 2) ? $urandom_range(0, NODES - 1) : pick_written(), $urandom);
		else begin
			c = $urandom_range(0, 1) ? CMD_READ : CMD_SPARE;
			queue_cmd(c, 1'($urandom_range(0, 1)), $urandom, $urandom, pick_written(),
				$urandom);
		end
	endfunction

	// driver: hold the beat until taken, gap at random between beats
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push <= 1'b0;
		end else begin
			if (push && !full)
				evaluate_node('{command, op_select, src_a_addr, src_b_addr, dest_addr, write_value});
			if (!push || !full) begin
				if (pending_cmds.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					next_cmd = pending_cmds.pop_front();
					push <= 1'b1;
					command <= next_cmd.cmd;
					op_select <= next_cmd.op;
					src_a_addr <= next_cmd.a;
					src_b_addr <= next_cmd.b;
					dest_addr <= next_cmd.d;
					write_value <= next_cmd.wv;
				end else
					push <= 1'b0;
			end
		end
	end

	// monitor: check each result beat, stall at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (expected_results.size() == 0)
					report_mismatch("unexpected result beat", result_value, 32'd0);
				else begin
					if (result_value !== expected_results[0].value)
						report_mismatch("result_value", result_value, expected_results[0].value);
					if (result_addr !== expected_results[0].addr)
						report_mismatch("result_addr", result_addr, expected_results[0].addr);
					void'(expected_results.pop_front());
				end
			end
			pop <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// stimulus: directed corner cases, then four phases of random commands with varied sender idling and receiver stalls
	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		queue_cmd(CMD_WRITE, OP_ADD, 0, 0, 0, 32'h3F800000);
		queue_cmd(CMD_WRITE, OP_ADD, 0, 0, 4095, 32'hBF800000);
		queue_cmd(CMD_WRITE, OP_ADD, 0, 0, 1, 32'h7F800000);
		queue_cmd(CMD_WRITE, OP_ADD, 0, 0, 2, 32'hFF800000);
		queue_cmd(CMD_WRITE, OP_ADD, 0, 0, 3, 32'h7F800001);
		queue_cmd(CMD_WRITE, OP_ADD, 0, 0, 4, 32'h00000001);
		queue_cmd(CMD_WRITE, OP_ADD, 0, 0, 5, 32'h80000000);
		queue_cmd(CMD_WRITE, OP_ADD, 0, 0, 6, 32'h7F7FFFFF);
		queue_cmd(CMD_WRITE, OP_ADD, 0, 0, 7, 32'h00800000);
		queue_cmd(CMD_WRITE, OP_ADD, 0, 0, 8, 32'h3F000000);
		queue_cmd(CMD_WRITE, OP_MUL, 4095, 4095, 9, 32'hFFFFFFFF);
		queue_cmd(CMD_EVAL, OP_ADD, 1, 2, 10, 0);	// inf minus inf
		queue_cmd(CMD_EVAL, OP_MUL, 5, 1, 11, 0);	// zero times inf
		queue_cmd(CMD_EVAL, OP_ADD, 3, 0, 12, 0);	// NaN operand
		queue_cmd(CMD_EVAL, OP_ADD, 4, 0, 13, 0);	// subnormal operand
		queue_cmd(CMD_EVAL, OP_MUL, 6, 6, 14, 0);	// overflow
		queue_cmd(CMD_EVAL, OP_MUL, 7, 8, 15, 0);	// tiny result
		queue_cmd(CMD_EVAL, OP_ADD, 0, 4095, 16, 0);	// opposite values give +0
		queue_cmd(CMD_EVAL, OP_ADD, 5, 5, 17, 0);	// -0 plus -0
		queue_cmd(CMD_EVAL, OP_ADD, 6, 6, 18, 0);
		queue_cmd(CMD_EVAL, OP_MUL, 0, 4095, 4095, 0);
		queue_cmd(CMD_EVAL, OP_ADD, 0, 0, 0, 0);
		queue_cmd(CMD_READ, OP_ADD, 0, 0, 4095, 0);
		queue_cmd(CMD_SPARE, OP_MUL, 4095, 4095, 0, 32'hFFFFFFFF);	// spare code reads

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 46; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 46; end
				default: begin send_idle_pct = 30; recv_stall_pct = 30; end
			endcase
			repeat (475) queue_random();
			while (pending_cmds.size() != 0 || push || expected_results.size() != 0)
				@(posedge clk);
		end
		repeat (20) @(posedge clk);
		if (expected_results.size() != 0)
			report_mismatch("results never arrived", expected_results.size(), 0);
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// watchdog
	initial begin
		#400000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
